FILE: rtl/stereo_peak_level_meter_db_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the stereo peak level meter
// Clocked, reset-qualified implication forms used by the checker file.
// ----------------------------------------------------------------------------
`ifndef STEREO_PEAK_LEVEL_METER_DB_MACROS_SVH
`define STEREO_PEAK_LEVEL_METER_DB_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define SPLM_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SPLM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/splm_pkg.sv
// ----------------------------------------------------------------------------
// splm_pkg
// Types and fixed constants of the stereo peak level meter.
// ----------------------------------------------------------------------------
package splm_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int POS_W      = 10;
  localparam int FS_W       = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_BAR_START  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BAR_END    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE = 2'd2;

  localparam logic [POS_W-1:0] BAR_START_RST  = 10'd15;
  localparam logic [POS_W-1:0] BAR_END_RST    = 10'd375;
  localparam logic [FS_W-1:0]  FULL_SCALE_RST = 8'd120;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
    logic                       block_last;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0] left_bar;
    logic [POS_W-1:0] right_bar;
    logic [POS_W-1:0] left_prev;
    logic [POS_W-1:0] right_prev;
  } out_item_t;

  typedef struct packed {
    logic [POS_W-1:0] bar_start;
    logic [POS_W-1:0] bar_end;
    logic [FS_W-1:0]  full_scale_db;
  } cfg_t;

  // Request to the bar calculator: one channel's span (0 means no signal)
  typedef struct packed {
    logic                go;
    logic [SAMPLE_W-1:0] span;
  } calc_req_t;

  typedef struct packed {
    logic             done;
    logic [POS_W-1:0] pos;
  } calc_rsp_t;

endpackage

FILE: rtl/stereo_peak_level_meter_db.sv
// ----------------------------------------------------------------------------
// stereo_peak_level_meter_db
// Stereo peak-to-peak tracker with dB bar positions at the end of each block.
// ----------------------------------------------------------------------------
// Frames without block_last are accepted back to back.
// Frame with block_last: the shared bar calculator runs once per channel
//   (a zero span skips straight to its final step), and the result then
//   waits for any output stall before it is loaded.
// Input stalls until the result is loaded. Reset: trackers cleared, previous
//   positions zero, registers at their documented defaults, output empty.
module stereo_peak_level_meter_db #(
  parameter int LOG_FRAC_BITS = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  splm_pkg::in_item_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output splm_pkg::out_item_t                 out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [splm_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [splm_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int SW = splm_pkg::SAMPLE_W;
  localparam int PW = splm_pkg::POS_W;

  localparam logic signed [SW-1:0] PEAK_HI_RST = 16'sh8000;
  localparam logic signed [SW-1:0] PEAK_LO_RST = 16'sh7fff;

  typedef enum logic [1:0] {T_IDLE, T_LEFT, T_RIGHT, T_OUT} top_state_e;

  top_state_e            state_q;
  splm_pkg::cfg_t        cfg_q;
  logic signed [SW-1:0]  l_hi_q, l_lo_q, r_hi_q, r_lo_q;
  logic [PW-1:0]         l_prev_q, r_prev_q;
  logic [PW-1:0]         l_bar_q, r_bar_q;
  logic                  go_q;
  logic                  out_valid_q;
  splm_pkg::out_item_t   out_data_q;

  splm_pkg::calc_req_t   calc_req;
  splm_pkg::calc_rsp_t   calc_rsp;

  logic accept;
  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != T_IDLE);
  assign cfg_ready_o = 1'b1;

  // Spans; a non-positive span goes to the bar start
  logic signed [SW:0] l_span_s, r_span_s;
  logic [SW-1:0]      l_span, r_span;
  assign l_span_s = {l_hi_q[SW-1], l_hi_q} - {l_lo_q[SW-1], l_lo_q};
  assign r_span_s = {r_hi_q[SW-1], r_hi_q} - {r_lo_q[SW-1], r_lo_q};
  assign l_span   = l_span_s[SW] ? '0 : l_span_s[SW-1:0];
  assign r_span   = r_span_s[SW] ? '0 : r_span_s[SW-1:0];

  assign calc_req.go   = go_q;
  assign calc_req.span = (state_q == T_RIGHT) ? r_span : l_span;

  splm_bar_calc #(
    .LOG_FRAC_BITS(LOG_FRAC_BITS)
  ) u_calc (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_q),
    .req_i (calc_req),
    .rsp_o (calc_rsp)
  );

  logic out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bar_start     <= splm_pkg::BAR_START_RST;
      cfg_q.bar_end       <= splm_pkg::BAR_END_RST;
      cfg_q.full_scale_db <= splm_pkg::FULL_SCALE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        splm_pkg::CFG_BAR_START:  cfg_q.bar_start     <= cfg_data_i[PW-1:0];
        splm_pkg::CFG_BAR_END:    cfg_q.bar_end       <= cfg_data_i[PW-1:0];
        splm_pkg::CFG_FULL_SCALE: cfg_q.full_scale_db <= cfg_data_i[splm_pkg::FS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      l_hi_q      <= PEAK_HI_RST;
      l_lo_q      <= PEAK_LO_RST;
      r_hi_q      <= PEAK_HI_RST;
      r_lo_q      <= PEAK_LO_RST;
      l_prev_q    <= '0;
      r_prev_q    <= '0;
      l_bar_q     <= '0;
      r_bar_q     <= '0;
      go_q        <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      go_q <= 1'b0;
      // in T_OUT a free output register is reloaded below
      if (out_valid_q && !out_stall_i && state_q != T_OUT) out_valid_q <= 1'b0;
      unique case (state_q)
        T_IDLE: begin
          if (accept) begin
            if (in_data_i.left_sample > l_hi_q)  l_hi_q <= in_data_i.left_sample;
            if (in_data_i.left_sample < l_lo_q)  l_lo_q <= in_data_i.left_sample;
            if (in_data_i.right_sample > r_hi_q) r_hi_q <= in_data_i.right_sample;
            if (in_data_i.right_sample < r_lo_q) r_lo_q <= in_data_i.right_sample;
            if (in_data_i.block_last) begin
              go_q    <= 1'b1;
              state_q <= T_LEFT;
            end
          end
        end
        T_LEFT: begin
          if (calc_rsp.done) begin
            l_bar_q <= calc_rsp.pos;
            go_q    <= 1'b1;
            state_q <= T_RIGHT;
          end
        end
        T_RIGHT: begin
          if (calc_rsp.done) begin
            r_bar_q <= calc_rsp.pos;
            state_q <= T_OUT;
          end
        end
        T_OUT: begin
          // wait for room in the output register
          if (out_free) begin
            out_valid_q           <= 1'b1;
            out_data_q.left_bar   <= l_bar_q;
            out_data_q.right_bar  <= r_bar_q;
            out_data_q.left_prev  <= l_prev_q;
            out_data_q.right_prev <= r_prev_q;
            l_prev_q <= l_bar_q;
            r_prev_q <= r_bar_q;
            l_hi_q   <= PEAK_HI_RST;
            l_lo_q   <= PEAK_LO_RST;
            r_hi_q   <= PEAK_HI_RST;
            r_lo_q   <= PEAK_LO_RST;
            state_q  <= T_IDLE;
          end
        end
        default: state_q <= T_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: rtl/splm_bar_calc.sv
// ----------------------------------------------------------------------------
// splm_bar_calc
// Span to bar position: log2 by repeated squaring, dB and bar scaling on one
// shared multiplier, then a restoring divide, under a small sequencer.
// ----------------------------------------------------------------------------
module splm_bar_calc #(
  parameter int LOG_FRAC_BITS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  splm_pkg::cfg_t     cfg_i,
  input  splm_pkg::calc_req_t req_i,
  output splm_pkg::calc_rsp_t rsp_o
);

  localparam int SW    = splm_pkg::SAMPLE_W;
  localparam int PW_   = splm_pkg::POS_W;
  localparam int FS_W_L = splm_pkg::FS_W;
  localparam int LW    = LOG_FRAC_BITS + 4;   // e (4 bits) and fraction
  localparam int DBM_W = LOG_FRAC_BITS + 7;   // dB magnitude in Q.F
  localparam int Q_W   = 17;                  // quotient of the bar scaling
  localparam int DBK_W = 19;
  localparam int MA_W  = (DBM_W > DBK_W) ? DBM_W : DBK_W;
  localparam int MB_W  = (LW > SW) ? LW : SW;
  localparam int PRD_W = MA_W + MB_W;
  localparam int CNT_N = (LOG_FRAC_BITS > Q_W) ? LOG_FRAC_BITS : Q_W;
  localparam int CNT_W = $clog2(CNT_N);

  // 20*log10(2) in Q16
  localparam logic [DBK_W-1:0] DB_PER_LOG2_Q16 = 19'd394566;

  function automatic int log2_full_scale(input int frac_bits);
    longint x;
    int     frac;
    x    = 65535;
    frac = 0;
    for (int i = 0; i < frac_bits; i++) begin
      x    = (x * x) >>> 15;
      frac = frac << 1;
      if (x >= 65536) begin
        frac = frac | 1;
        x    = x >>> 1;
      end
    end
    return (15 << frac_bits) | frac;
  endfunction

  localparam logic [LW-1:0] L_FULL = LW'(log2_full_scale(LOG_FRAC_BITS));

  typedef enum logic [3:0] {
    C_IDLE, C_SQ, C_SQN, C_DB, C_DBN, C_SC, C_SCN, C_DIV, C_FIN
  } calc_state_e;

  calc_state_e              state_q;
  logic [SW-1:0]            x_q;
  logic [3:0]               exp_q;
  logic [LOG_FRAC_BITS-1:0] frac_q;
  logic [DBM_W-1:0]         dbm_q;
  logic [Q_W-1:0]           dvd_q;
  logic [FS_W_L-1:0]        rem_q;
  logic [CNT_W-1:0]         cnt_q;
  logic                     zero_q;
  logic [PRD_W-1:0]         prod_q;
  logic                     done_q;
  logic [PW_-1:0]           pos_q;

  // Leading one and normalisation of the requested span
  logic [3:0]    lead;
  logic [SW-1:0] norm;
  always_comb begin
    lead = '0;
    for (int i = 0; i < SW; i++) begin
      if (req_i.span[i]) lead = 4'(i);
    end
    norm = req_i.span << (4'd15 - lead);
  end

  // Squaring step result
  logic [SW:0] sq;
  assign sq = prod_q[15 +: SW+1];

  logic [LW-1:0] neg_d;
  assign neg_d = L_FULL - {exp_q, frac_q};

  logic signed [PW_:0] diff_s;
  logic [PW_-1:0]      diff_mag;
  assign diff_s   = $signed({1'b0, cfg_i.bar_end}) - $signed({1'b0, cfg_i.bar_start});
  assign diff_mag = diff_s[PW_] ? PW_'(-diff_s) : diff_s[PW_-1:0];

  logic [FS_W_L-1:0] fs_eff;
  assign fs_eff = (cfg_i.full_scale_db == '0) ? FS_W_L'(1) : cfg_i.full_scale_db;

  // Restoring divide step
  logic [FS_W_L:0] rem_sh;
  logic [FS_W_L:0] rem_sub;
  logic            qbit;
  assign rem_sh  = {rem_q, dvd_q[Q_W-1]};
  assign rem_sub = rem_sh - {1'b0, fs_eff};
  assign qbit    = (rem_sh >= {1'b0, fs_eff});

  // Shared multiplier operands
  logic [MA_W-1:0] mul_a;
  logic [MB_W-1:0] mul_b;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      C_SQ: begin
        mul_a = MA_W'(x_q);
        mul_b = MB_W'(x_q);
      end
      C_DB: begin
        mul_a = MA_W'(DB_PER_LOG2_Q16);
        mul_b = MB_W'(neg_d);
      end
      C_SC: begin
        mul_a = MA_W'(dbm_q);
        mul_b = MB_W'(diff_mag);
      end
      default: ;
    endcase
  end

  // Final position and clamp; bar_end is tested first
  localparam int PS_W = Q_W + 2;
  logic signed [PS_W-1:0] end_s, start_s, q_s, pos_s;
  logic [PW_-1:0]         pos_clamped;
  always_comb begin
    end_s   = $signed(PS_W'(cfg_i.bar_end));
    start_s = $signed(PS_W'(cfg_i.bar_start));
    q_s     = $signed(PS_W'(dvd_q));
    pos_s   = diff_s[PW_] ? (end_s + q_s) : (end_s - q_s);
    if (pos_s > end_s) begin
      pos_clamped = cfg_i.bar_end;
    end else if (pos_s < start_s) begin
      pos_clamped = cfg_i.bar_start;
    end else begin
      pos_clamped = pos_s[PW_-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      x_q     <= '0;
      exp_q   <= '0;
      frac_q  <= '0;
      dbm_q   <= '0;
      dvd_q   <= '0;
      rem_q   <= '0;
      cnt_q   <= '0;
      zero_q  <= 1'b0;
      prod_q  <= '0;
      done_q  <= 1'b0;
      pos_q   <= '0;
    end else begin
      prod_q <= PRD_W'(mul_a) * PRD_W'(mul_b);
      done_q <= 1'b0;
      unique case (state_q)
        C_IDLE: begin
          if (req_i.go) begin
            x_q    <= norm;
            exp_q  <= lead;
            frac_q <= '0;
            cnt_q  <= '0;
            zero_q <= (req_i.span == '0);
            state_q <= (req_i.span == '0) ? C_FIN : C_SQ;
          end
        end
        C_SQ: state_q <= C_SQN;
        C_SQN: begin
          x_q    <= sq[SW] ? sq[SW:1] : sq[SW-1:0];
          frac_q <= {frac_q[LOG_FRAC_BITS-2:0], sq[SW]};
          cnt_q  <= cnt_q + CNT_W'(1);
          state_q <= (cnt_q == CNT_W'(LOG_FRAC_BITS - 1)) ? C_DB : C_SQ;
        end
        C_DB:  state_q <= C_DBN;
        C_DBN: begin
          dbm_q   <= prod_q[16 +: DBM_W];
          state_q <= C_SC;
        end
        C_SC:  state_q <= C_SCN;
        C_SCN: begin
          // floor(m / (fs << F)) == floor((m >> F) / fs)
          dvd_q   <= prod_q[LOG_FRAC_BITS +: Q_W];
          rem_q   <= '0;
          cnt_q   <= '0;
          state_q <= C_DIV;
        end
        C_DIV: begin
          rem_q   <= qbit ? rem_sub[FS_W_L-1:0] : rem_sh[FS_W_L-1:0];
          dvd_q   <= {dvd_q[Q_W-2:0], qbit};
          cnt_q   <= cnt_q + CNT_W'(1);
          if (cnt_q == CNT_W'(Q_W - 1)) state_q <= C_FIN;
        end
        C_FIN: begin
          pos_q   <= zero_q ? cfg_i.bar_start : pos_clamped;
          done_q  <= 1'b1;
          state_q <= C_IDLE;
        end
        default: state_q <= C_IDLE;
      endcase
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.pos  = pos_q;

endmodule

FILE: rtl/splm_checker.sv
// ----------------------------------------------------------------------------
// splm_checker
// Port-level checks of the level meter, bound to the top level.
// ----------------------------------------------------------------------------
`include "stereo_peak_level_meter_db_macros.svh"

module splm_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input splm_pkg::in_item_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input splm_pkg::out_item_t out_data_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  `SPLM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "stalled result dropped or changed")
  `SPLM_ASSERT_NEXT(a_last_busy, clk_i, rst_ni, in_acc && in_data_i.block_last, in_stall_o, "block end request not followed by busy")
  `SPLM_ASSERT_NEXT(a_frame_fast, clk_i, rst_ni, in_acc && !in_data_i.block_last, !in_stall_o, "plain frame stalled the input")
  `SPLM_ASSERT_SAME(a_result_src, clk_i, rst_ni, $rose(out_valid_o), $past(in_stall_o), "result appeared without block end processing")

endmodule

bind stereo_peak_level_meter_db splm_checker u_splm_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .in_data_i  (in_data_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o)
);
